>>> rtl/lcag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcag_pkg;

    localparam int DIM_W     = 7;
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 12;
    localparam int GEN_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - GEN_W - 2;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TOGGLE  = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_ADVANCE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // input transfer, start index split
        logic tgl_wr;     // write back toggled row
        logic gen_start;  // start generation sweep
        logic clr_start;  // start clearing pass
        logic capture;    // latch addressed cell
        logic out_load;   // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic  div_done;
        logic  gen_done;
        logic  clr_done;
        logic  out_free;
        func_t func;
    } st_t;

endpackage

`default_nettype wire

>>> rtl/lcag_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lcag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/lcag_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lcag_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire lcag_pkg::st_t st,
    output lcag_pkg::cmd_t     cmd
);

    import lcag_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_TGL_RD,
        ST_TGL_WR,
        ST_GEN_GO,
        ST_GEN_RUN,
        ST_CLR_GO,
        ST_CLR_RUN,
        ST_FETCH,
        ST_CAPT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT: begin
                if (st.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (st.div_done) begin
                    case (st.func)
                        FUNC_TOGGLE:  state_next = ST_TGL_RD;
                        FUNC_READ:    state_next = ST_FETCH;
                        FUNC_ADVANCE: state_next = ST_GEN_GO;
                        FUNC_CLEAR:   state_next = ST_CLR_GO;
                        default:      state_next = ST_FETCH;
                    endcase
                end
            end
            ST_TGL_RD: begin
                state_next = ST_TGL_WR;
            end
            ST_TGL_WR: begin
                cmd.tgl_wr = 1'b1;
                state_next = ST_FETCH;
            end
            ST_GEN_GO: begin
                cmd.gen_start = 1'b1;
                state_next    = ST_GEN_RUN;
            end
            ST_GEN_RUN: begin
                if (st.gen_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_CLR_GO: begin
                cmd.clr_start = 1'b1;
                state_next    = ST_CLR_RUN;
            end
            ST_CLR_RUN: begin
                if (st.clr_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_CAPT;
            end
            ST_CAPT: begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/lcag_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lcag_dp #(
    parameter int MAX_WIDTH  = lcag_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lcag_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire lcag_pkg::cmd_t                   cmd,
    output lcag_pkg::st_t                         st,
    input  wire logic [lcag_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [lcag_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lcag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcag_pkg::DIM_W-1:0]       cfg_data
);

    import lcag_pkg::*;

    localparam int RAW    = $clog2(MAX_HEIGHT);
    localparam int ROWC_W = $clog2(MAX_HEIGHT + 2);
    localparam int CAW    = $clog2(MAX_WIDTH);
    localparam int PROD_W = 2 * DIM_W;
    localparam int DIVC_W = $clog2(IDX_W);
    localparam int CHK_W  = IDX_W + DIM_W + 1;

    localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(IDX_W - 1);
    localparam logic [RAW-1:0]    CLR_LAST = RAW'(MAX_HEIGHT - 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            r = DIM_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [PROD_W-1:0] total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= GRID_WIDTH_RST;
            height_reg <= GRID_HEIGHT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_WIDTH:  width_reg  <= cfg_data;
                REG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = clamp_dim(width_reg, MAX_WIDTH);
    assign h_eff = clamp_dim(height_reg, MAX_HEIGHT);
    assign total = PROD_W'(w_eff) * PROD_W'(h_eff);

    // item and index split: restoring division, one quotient bit per cycle
    logic [FUNC_W-1:0] func_in;
    logic [IDX_W-1:0]  idx_in;
    func_t             func_reg;
    logic              invalid_reg;
    logic [IDX_W-1:0]  idx_reg, idx_sh_reg, q_reg;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIVC_W-1:0] div_cnt_reg;
    logic              div_active_reg;
    logic [DIM_W:0]    trial, diff;
    logic              trial_ge;
    logic [RAW-1:0]    row_sel;
    logic [CAW-1:0]    col_sel;

    assign func_in  = s_tdata[FUNC_W-1:0];
    assign idx_in   = s_tdata[FUNC_W +: IDX_W];
    assign trial    = {rem_reg, idx_sh_reg[IDX_W-1]};
    assign diff     = trial - {1'b0, w_eff};
    assign trial_ge = trial >= {1'b0, w_eff};
    assign rem_next = trial_ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
    assign row_sel  = RAW'(q_reg);
    assign col_sel  = CAW'(rem_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_active_reg <= 1'b0;
            div_cnt_reg    <= '0;
        end else if (cmd.load) begin
            div_active_reg <= 1'b1;
            div_cnt_reg    <= '0;
        end else if (div_active_reg) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_cnt_reg == DIV_LAST) begin
                div_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg    <= func_t'(func_in);
            idx_reg     <= idx_in;
            idx_sh_reg  <= idx_in;
            q_reg       <= '0;
            rem_reg     <= '0;
            invalid_reg <= PROD_W'(idx_in) >= total;
        end else if (div_active_reg) begin
            idx_sh_reg <= {idx_sh_reg[IDX_W-2:0], 1'b0};
            q_reg      <= {q_reg[IDX_W-2:0], trial_ge};
            rem_reg    <= rem_next;
        end
    end

    // grid memory
    logic                 ram_we;
    logic [RAW-1:0]       ram_waddr, ram_raddr;
    logic [MAX_WIDTH-1:0] ram_wdata, ram_rdata;

    lcag_ram #(
        .WIDTH(MAX_WIDTH),
        .DEPTH(MAX_HEIGHT)
    ) u_grid (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // generation sweep: three-row window, one row per cycle
    logic                 gen_active_reg, arr_valid_reg;
    logic [ROWC_W-1:0]    rd_cnt_reg, arr_row_reg, h_cnt;
    logic [MAX_WIDTH-1:0] prev_reg, cur_reg, below_raw, col_mask, new_row;
    logic [MAX_WIDTH+1:0] pa, pm, pb;
    logic                 gen_issue, gen_wr, gen_last;
    logic [GEN_W-1:0]     gen_count_reg;
    logic                 clr_active_reg;
    logic [RAW-1:0]       clr_cnt_reg;

    assign h_cnt     = ROWC_W'(h_eff);
    assign gen_issue = gen_active_reg && (rd_cnt_reg <= h_cnt);
    assign gen_wr    = arr_valid_reg && (arr_row_reg != '0);
    assign gen_last  = arr_valid_reg && (arr_row_reg == h_cnt);
    assign below_raw = (arr_row_reg < h_cnt) ? ram_rdata : '0;

    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            col_mask[c] = c < int'(w_eff);
        end
    end

    assign pa = {1'b0, prev_reg & col_mask, 1'b0};
    assign pm = {1'b0, cur_reg & col_mask, 1'b0};
    assign pb = {1'b0, below_raw & col_mask, 1'b0};

    always_comb begin
        logic [3:0] n;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
              + 4'(pm[c]) + 4'(pm[c+2])
              + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
            if (col_mask[c]) begin
                new_row[c] = (n == 4'd3) || (pm[c+1] && (n == 4'd2));
            end else begin
                new_row[c] = cur_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_active_reg <= 1'b0;
            arr_valid_reg  <= 1'b0;
            rd_cnt_reg     <= '0;
            arr_row_reg    <= '0;
        end else begin
            arr_valid_reg <= gen_issue;
            arr_row_reg   <= rd_cnt_reg;
            if (cmd.gen_start) begin
                gen_active_reg <= 1'b1;
                rd_cnt_reg     <= '0;
            end else begin
                if (gen_issue) begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (gen_last) begin
                    gen_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.gen_start) begin
            prev_reg <= '0;
            cur_reg  <= '0;
        end else if (arr_valid_reg) begin
            prev_reg <= cur_reg;
            cur_reg  <= below_raw;
        end
    end

    // clearing pass, also run once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (cmd.clr_start) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_LAST) begin
                clr_active_reg <= 1'b0;
                clr_cnt_reg    <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_count_reg <= '0;
        end else if (cmd.clr_start) begin
            gen_count_reg <= '0;
        end else if (gen_last) begin
            gen_count_reg <= gen_count_reg + 1'b1;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = row_sel;
        ram_wdata = ram_rdata ^ (MAX_WIDTH'(1) << col_sel);
        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (gen_wr) begin
            ram_we    = 1'b1;
            ram_waddr = RAW'(arr_row_reg - 1'b1);
            ram_wdata = new_row;
        end else if (cmd.tgl_wr && !invalid_reg) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = gen_issue ? RAW'(rd_cnt_reg) : row_sel;

    // result and output register
    logic                 alive_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            alive_reg <= !invalid_reg && ram_rdata[col_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {{M_PAD_W{1'b0}}, invalid_reg, gen_count_reg, alive_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign st.div_done = div_active_reg && (div_cnt_reg == DIV_LAST);
    assign st.gen_done = gen_last;
    assign st.clr_done = clr_active_reg && (clr_cnt_reg == CLR_LAST);
    assign st.out_free = !m_valid_reg || m_tready;
    assign st.func     = func_reg;

    a_gen_wr_in_area: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_wr |-> (arr_row_reg <= h_cnt))
        else $error("generation write outside active rows");

    a_gen_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_wr && gen_issue && (rd_cnt_reg < h_cnt)) |->
            (RAW'(rd_cnt_reg) != RAW'(arr_row_reg - 1'b1)))
        else $error("window read hits the row being written");

    a_div_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_active_reg && (div_cnt_reg == DIV_LAST)) |=>
            (invalid_reg ||
             ((CHK_W'(q_reg) * CHK_W'(w_eff) + CHK_W'(rem_reg)) == CHK_W'(idx_reg))))
        else $error("row/column split does not match index");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten before transfer");

    a_clear_zeroes_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_start |=> (gen_count_reg == '0))
        else $error("clear did not reset generation count");

endmodule

`default_nettype wire

>>> rtl/life_cellular_automaton_grid_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded B3/S23 grid. One command per s_ transfer (toggle, read, advance,
// clear); exactly one m_ transfer per command with the addressed cell, the
// generation count and an out-of-range flag.
// Grid size is set through the cfg_ write channel (always ready); the user
// must write it only while the block is idle; the block does not enforce this.
// Every command first splits the cell index into row and column with a
// bit-serial divider. Advance sweeps the grid, reading one row per cycle from
// the single grid RAM through a three-row window; clear zeroes all MAX_HEIGHT
// RAM rows, one row per cycle.
// One command is processed at a time; s_tready is high only when idle, which
// starts the cycle after the result is loaded. The output register frees the
// core, so the next command is taken while a result still waits for m_tready;
// a second finished result then waits in the core with s_tready low until the
// first is taken.
// After aresetn all MAX_HEIGHT rows of the grid RAM are zeroed, s_tready low
// meanwhile; width and height return to 64, generation count to zero.
module life_cellular_automaton_grid_unit #(
    parameter int MAX_WIDTH  = lcag_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lcag_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lcag_pkg::S_TDATA_W-1:0] s_tdata,   // func, cell_index
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [lcag_pkg::M_TDATA_W-1:0] m_tdata,   // cell_alive, generation_count,
                                                           // index_invalid
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lcag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcag_pkg::DIM_W-1:0]     cfg_data
);

    import lcag_pkg::*;

    cmd_t cmd;
    st_t  st;

    lcag_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .st      (st),
        .cmd     (cmd)
    );

    lcag_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

endmodule

`default_nettype wire
